@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

    localparam int VALUE_BITS = 32;

    // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1).
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_BITS   = $clog2(NUM_DIGITS);

    // Double-dabble shift steps done by one pipeline stage.
    localparam int STEP_BITS  = 8;
    localparam int NUM_STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = NUM_STAGES * STEP_BITS;

    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;

    // Payload carried down the conversion pipeline.
    typedef struct packed {
        logic                           neg;
        logic [NUM_DIGITS-1:0][3:0]     bcd;
        logic [PAD_BITS-1:0]            bin;
    } dd_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Each number passes the abs register, the double-dabble stage registers, then the
// serializer, which emits one character per cycle while m_tready is high; a number
//   is 1 to 11 characters (sign plus up to ten digits).
// Input beats enter the abs/double-dabble pipeline every cycle until it fills.
// Reset: aresetn synchronous, active low; clears all valid and sequencer state.
module signed_int_to_decimal_ascii_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream: one integer per beat.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [itoa_pkg::VALUE_BITS-1:0]  s_tdata,   // [VALUE_BITS-1:0] value
    // Output stream: one ASCII character per beat.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [6:0] char_code, [7] zero
    output logic                             m_tlast    // is_last
);
    import itoa_pkg::*;

    // Stage handshake chain: index 0 is the abs stage output, index k the
    // output of double-dabble stage k.
    logic stg_valid [NUM_STAGES+1];
    logic stg_ready [NUM_STAGES+1];
    dd_t  stg_data  [NUM_STAGES+1];
    logic [6:0] char_code;

    // Stage 0: sign split and two's complement magnitude.
    itoa_abs u_abs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Binary to BCD, STEP_BITS shift steps per stage.
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_dabble
        itoa_dabble u_dabble (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    // Serializer: skips leading zeros, emits sign then digits, holds
    // the character in an output register so the next number can load
    // while the last one waits.
    itoa_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NUM_STAGES]),
        .in_ready  (stg_ready[NUM_STAGES]),
        .in_data   (stg_data[NUM_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (char_code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, char_code};

    // Output register is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Only a minus sign or a decimal digit ever leaves the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (char_code == CHAR_MINUS) ||
                     ((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 7'd9)))
        else $error("bad character code");

    // A minus sign is always followed by a digit, never ends a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (char_code == CHAR_MINUS)) |-> !m_tlast)
        else $error("minus sign flagged last");

    // After a minus sign is taken, the next beat is a digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (char_code == CHAR_MINUS)) |=>
            (!m_tvalid || (char_code != CHAR_MINUS)))
        else $error("two minus signs in a row");

endmodule

@@ rtl/itoa_abs.sv @@
module itoa_abs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [itoa_pkg::VALUE_BITS-1:0]  in_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output itoa_pkg::dd_t                    out_data
);
    import itoa_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    dd_t                   data_reg;
    dd_t                   data_next;
    logic [VALUE_BITS-1:0] mag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Magnitude fits VALUE_BITS unsigned bits, most negative value included.
    always_comb begin
        mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
        data_next.neg = in_value[VALUE_BITS-1];
        data_next.bcd = '0;
        data_next.bin = PAD_BITS'(mag);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/itoa_dabble.sv @@
module itoa_dabble (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  itoa_pkg::dd_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output itoa_pkg::dd_t  out_data
);
    import itoa_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    dd_t                        data_reg;
    dd_t                        data_next;
    logic [NUM_DIGITS-1:0][3:0] bcd;
    logic [PAD_BITS-1:0]        bin;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // STEP_BITS rounds of add-3 then shift left.
    always_comb begin
        bcd = in_data.bcd;
        bin = in_data.bin;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd[d] >= 4'd5) begin
                    bcd[d] = bcd[d] + 4'd3;
                end
            end
            {bcd, bin} = {bcd, bin} << 1;
        end
        data_next.neg = in_data.neg;
        data_next.bcd = bcd;
        data_next.bin = bin;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/itoa_serial.sv @@
module itoa_serial (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  itoa_pkg::dd_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     out_char,
    output logic           out_last
);
    import itoa_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       sign_reg, sign_next;
    logic [IDX_BITS-1:0]        idx_reg, idx_next;
    logic [NUM_DIGITS-1:0][3:0] digits_reg;
    logic                       ovalid_reg, ovalid_next;
    logic [6:0]                 char_reg;
    logic                       last_reg;
    logic [6:0]                 char_cur;
    logic                       last_cur;
    logic                       out_adv;
    logic                       emit;
    logic                       load;
    logic [IDX_BITS-1:0]        msd;

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    assign out_adv  = !ovalid_reg || out_ready;
    assign emit     = busy_reg && out_adv;
    assign in_ready = !busy_reg || (out_adv && !sign_reg && (idx_reg == '0));
    assign load     = in_valid && in_ready;

    // Index of the most significant nonzero digit, zero for a zero value.
    always_comb begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (in_data.bcd[i] != 4'd0) begin
                msd = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        if (sign_reg) begin
            char_cur = CHAR_MINUS;
            last_cur = 1'b0;
        end else begin
            char_cur = CHAR_ZERO + 7'(digits_reg[idx_reg]);
            last_cur = (idx_reg == '0);
        end
    end

    always_comb begin
        busy_next   = busy_reg;
        sign_next   = sign_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        if (out_adv) begin
            ovalid_next = busy_reg;
        end
        if (emit) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else if (idx_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - IDX_BITS'(1);
            end
        end
        if (load) begin
            busy_next = 1'b1;
            sign_next = in_data.neg;
            idx_next  = msd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            sign_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            sign_reg   <= sign_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= in_data.bcd;
        end
        if (emit) begin
            char_reg <= char_cur;
            last_reg <= last_cur;
        end
    end

endmodule
